// ===== sv/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

	localparam int KEY_W       = 31;
	localparam int HANDLE_W    = 6;
	localparam int COUNT_W     = 7;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 48;
	localparam int OUT_USER_W  = 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    key;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic start;      // input transfer: latch item, set up op
		logic rd_parent;  // read parent of hole
		logic up_move;    // parent moves down into hole
		logic pop_load;   // take root as result, last entry becomes sift item
		logic rd_child;   // read both children of hole
		logic dn_move;    // larger child moves up into hole
		logic place;      // write sift item into hole
		logic emit;       // load output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic leaf;
		logic up_go;
		logic dn_go;
		logic out_free;
	} status_t;

endpackage

// ===== sv/mhpq_ctrl.sv =====
// Sequencer for push sift-up and pop sift-down.
module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_op,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_POP_LD,
		S_DN_CHK,
		S_DN_CMP,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.start = 1'b1;
					if (in_op == OP_PUSH) begin
						state_nxt = st.full ? S_FIN : S_UP_CHK;
					end else begin
						state_nxt = st.empty ? S_FIN : S_POP_LD;
					end
				end
			end
			S_UP_CHK: begin
				if (st.at_root) begin
					cmd.place = 1'b1;
					state_nxt = S_FIN;
				end else begin
					cmd.rd_parent = 1'b1;
					state_nxt     = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (st.up_go) begin
					cmd.up_move = 1'b1;
					state_nxt   = S_UP_CHK;
				end else begin
					cmd.place = 1'b1;
					state_nxt = S_FIN;
				end
			end
			S_POP_LD: begin
				cmd.pop_load = 1'b1;
				state_nxt    = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (st.leaf) begin
					cmd.place = 1'b1;
					state_nxt = S_FIN;
				end else begin
					cmd.rd_child = 1'b1;
					state_nxt    = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (st.dn_go) begin
					cmd.dn_move = 1'b1;
					state_nxt   = S_DN_CHK;
				end else begin
					cmd.place = 1'b1;
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== sv/mhpq_dp.sv =====
// Heap storage, hole position, sift compares and the output register.
module mhpq_dp
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               st,
	input  logic                  in_op,
	input  entry_t                in_entry,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [OUT_USER_W-1:0] out_user
);

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = ADDR_W + 1;
	localparam int PAD_W  = OUT_DATA_W - COUNT_W - HANDLE_W - KEY_W;

	entry_t mem [CAPACITY];

	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] pos_q;
	entry_t            cur_q;
	entry_t            rd_a_q;
	entry_t            rd_b_q;
	entry_t            res_q;
	logic              res_valid_q;
	logic              res_rej_q;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	logic [ADDR_W-1:0] parent;
	logic [IDX_W-1:0]  lc;
	logic [IDX_W-1:0]  rc;
	logic [IDX_W-1:0]  fill_ext;
	logic              rc_ok;
	logic              sel_r;
	entry_t            child;
	logic [ADDR_W-1:0] child_pos;
	logic              rd_a_en;
	logic              rd_b_en;
	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;

	assign parent   = (pos_q - ADDR_W'(1)) >> 1;
	assign lc       = {pos_q, 1'b1};
	assign rc       = IDX_W'({pos_q, 1'b0}) + IDX_W'(2);
	assign fill_ext = IDX_W'(fill_q);
	assign rc_ok    = rc < fill_ext;

	// left child wins on equal keys
	assign sel_r     = rc_ok && (rd_b_q.key > rd_a_q.key);
	assign child     = sel_r ? rd_b_q : rd_a_q;
	assign child_pos = sel_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

	assign st.full     = (fill_q == CNT_W'(CAPACITY));
	assign st.empty    = (fill_q == '0);
	assign st.at_root  = (pos_q == '0);
	assign st.leaf     = (lc >= fill_ext);
	assign st.up_go    = (rd_a_q.key < cur_q.key);
	assign st.dn_go    = (child.key > cur_q.key);
	assign st.out_free = !out_valid_q || out_ready;

	always_comb begin
		rd_a_en = 1'b0;
		rd_b_en = 1'b0;
		addr_a  = '0;
		addr_b  = '0;
		if (cmd.start && in_op == OP_POP) begin
			rd_a_en = 1'b1;
			rd_b_en = 1'b1;
			addr_b  = ADDR_W'(fill_q - CNT_W'(1));
		end else if (cmd.rd_parent) begin
			rd_a_en = 1'b1;
			addr_a  = parent;
		end else if (cmd.rd_child) begin
			rd_a_en = 1'b1;
			rd_b_en = 1'b1;
			addr_a  = lc[ADDR_W-1:0];
			addr_b  = rc_ok ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
		end
	end

	always_comb begin
		wr_en   = cmd.place || cmd.up_move || cmd.dn_move;
		wr_addr = pos_q;
		if (cmd.up_move) begin
			wr_data = rd_a_q;
		end else if (cmd.dn_move) begin
			wr_data = child;
		end else begin
			wr_data = cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_a_en) begin
			rd_a_q <= mem[addr_a];
		end
		if (rd_b_en) begin
			rd_b_q <= mem[addr_b];
		end
	end

	// sift item, hole position and result fields
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q <= in_entry;
			res_q <= '0;
			if (in_op == OP_PUSH) begin
				pos_q <= ADDR_W'(fill_q);
			end
		end
		if (cmd.pop_load) begin
			res_q <= rd_a_q;
			cur_q <= rd_b_q;
			pos_q <= '0;
		end
		if (cmd.up_move) begin
			pos_q <= parent;
		end
		if (cmd.dn_move) begin
			pos_q <= child_pos;
		end
		if (cmd.emit) begin
			out_data_q <= {PAD_W'(0), COUNT_W'(fill_q), res_q.handle, res_q.key};
			out_user_q <= {res_rej_q, res_valid_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			res_valid_q <= 1'b0;
			res_rej_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				res_valid_q <= 1'b0;
				res_rej_q   <= (in_op == OP_PUSH) && st.full;
				if (in_op == OP_PUSH && !st.full) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (cmd.pop_load) begin
				res_valid_q <= 1'b1;
				fill_q      <= fill_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

// ===== sv/max_heap_priority_queue_unit.sv =====
// Max-heap priority queue: push sifts up, pop takes the root and sifts down.
// A rejected push or an empty pop goes straight to the result. One item at a time;
// each level moved takes a read step and a compare/write step, and a sift ends by
// writing the sift item into the hole before the result is loaded into the output
// register. A new item is taken while one result waits in the output register.
// arst_n clears the entry count and control; heap contents are not cleared.
module max_heap_priority_queue_unit
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // push_key[30:0], push_handle[36:31]
	input  logic                  s_axis_tuser,  // opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // pop_key[30:0], pop_handle[36:31],
	                                             // entry_count[43:37]
	output logic [OUT_USER_W-1:0] m_axis_tuser   // pop_valid[0], push_rejected[1]
);

	cmd_t    cmd;
	status_t st;
	entry_t  in_entry;

	assign in_entry.key    = s_axis_tdata[KEY_W-1:0];
	assign in_entry.handle = s_axis_tdata[KEY_W+HANDLE_W-1:KEY_W];

	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mhpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_op     (s_axis_tuser),
		.in_entry  (in_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("pop_valid and push_rejected both set");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_PUSH && !st.full)
		|=> !st.empty)
		else $error("accepted push left heap empty");

	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(st.full && st.empty))
		else $error("heap both full and empty");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.place, cmd.up_move, cmd.dn_move, cmd.rd_parent, cmd.rd_child}))
		else $error("conflicting heap memory commands");

endmodule
